@@ hdl/ste_pkg.sv @@
// ----------------------------------------------------------------------------
// ste_pkg
// Shared types and constants of the sorted table engine: operation codes,
// field widths and the command bundle sent to every cell.
// ----------------------------------------------------------------------------
package ste_pkg;

    localparam int OP_W   = 3;
    localparam int VAL_W  = 32;
    localparam int POS_W  = 5;
    localparam int RANK_W = 5;
    localparam int CNT_W  = 5;

    localparam logic [OP_W-1:0] OP_INSERT       = 3'd0;
    localparam logic [OP_W-1:0] OP_REMOVE_VALUE = 3'd1;
    localparam logic [OP_W-1:0] OP_REMOVE_AT    = 3'd2;
    localparam logic [OP_W-1:0] OP_FIND_RANK    = 3'd3;
    localparam logic [OP_W-1:0] OP_READ_AT      = 3'd4;
    localparam logic [OP_W-1:0] OP_CLEAR        = 3'd5;

    // Broadcast to all cells in the cycle a transfer is taken
    typedef struct packed {
        logic                    ins_en;   // insert, shift toward the tail
        logic                    rmv_en;   // remove first equal entry
        logic                    rma_en;   // remove at position
        logic signed [VAL_W-1:0] value;
    } t_cell_cmd;

endpackage

@@ hdl/sorted_table_engine_unit.sv @@
// ----------------------------------------------------------------------------
// sorted_table_engine_unit
// Ordered table of signed words kept in a chain of compare-and-shift cells.
// The result is registered on the input transfer and is presented in the cycle after it.
// Throughput: one operation per cycle; all cells compare in parallel and
// shift in the same cycle, so the next input is taken while m_tready holds.
// Reset clears the fill count and the output valid; entry storage is not
// cleared, slots past the count are never read.
// ----------------------------------------------------------------------------
module sorted_table_engine_unit #(
    parameter int DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [31:0] value, [36:32] position, zero pad
    input  logic [2:0]  s_tuser,   // [2:0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // [0] ok, [32:1] read_value, [37:33] rank,
                                   // [42:38] count, zero pad
);
    import ste_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > POS_W) ? CW : POS_W;

    // input fields
    logic [OP_W-1:0]         in_op;
    logic signed [VAL_W-1:0] in_value;
    logic [POS_W-1:0]        in_pos;
    logic                    accept;

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;

    logic                    r_m_valid;
    logic                    r_ok;
    logic signed [VAL_W-1:0] r_rd;
    logic [RANK_W-1:0]       r_rank;
    logic [CNT_W-1:0]        r_cnt_out;

    t_cell_cmd               cmd;
    logic [DEPTH-1:0]        lt_vec;
    logic [DEPTH:0]          lt_ext;
    logic [DEPTH-1:0]        eq_vec;
    logic [DEPTH-1:0]        valid_vec;
    logic [DEPTH-1:0]        rm_sel;
    logic [DEPTH-1:0]        rd_sel;
    logic signed [VAL_W-1:0] cell_entry [DEPTH];
    logic signed [VAL_W-1:0] cell_rd    [DEPTH];

    logic [PW-1:0]           pos_ext;
    logic [PW-1:0]           cnt_ext;
    logic [PW-1:0]           rd_slot;
    logic [CW-1:0]           smaller;
    logic signed [VAL_W-1:0] rd_any;
    logic                    full;
    logic                    empty;
    logic                    found;
    logic                    pos_ok;

    logic                    ok_c;
    logic signed [VAL_W-1:0] rd_c;
    logic [PW:0]             rank_c;
    logic [PW-1:0]           cnt_next_ext;

    assign in_op    = s_tuser;
    assign in_value = s_tdata[31:0];
    assign in_pos   = s_tdata[36:32];

    assign s_tready = !r_m_valid || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign pos_ext = PW'(in_pos);
    assign cnt_ext = PW'(r_count);
    assign full    = (r_count == CW'(DEPTH));
    assign empty   = (r_count == '0);
    assign found   = |eq_vec;
    assign pos_ok  = (pos_ext != '0) && (pos_ext <= cnt_ext);
    assign rd_slot = (pos_ext < cnt_ext) ? pos_ext : (cnt_ext - PW'(1));

    always_comb begin
        cmd.ins_en = accept && (in_op == OP_INSERT) && !full;
        cmd.rmv_en = accept && (in_op == OP_REMOVE_VALUE) && found;
        cmd.rma_en = accept && (in_op == OP_REMOVE_AT) && pos_ok;
        cmd.value  = in_value;
    end

    // per-slot selects against constant indexes
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            valid_vec[i] = (PW'(i) < cnt_ext);
            rm_sel[i]    = (PW'(i + 1) >= pos_ext);
            rd_sel[i]    = (PW'(i) == rd_slot);
        end
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic                    left_lt;
            logic signed [VAL_W-1:0] left_entry;
            logic signed [VAL_W-1:0] right_entry;

            if (g == 0) begin : g_head
                assign left_lt    = 1'b1;
                assign left_entry = '0;
            end else begin : g_mid
                assign left_lt    = lt_vec[g-1];
                assign left_entry = cell_entry[g-1];
            end

            if (g == DEPTH - 1) begin : g_tail
                assign right_entry = cell_entry[g];
            end else begin : g_body
                assign right_entry = cell_entry[g+1];
            end

            ste_cell u_cell (
                .i_clk         (i_clk),
                .i_cmd         (cmd),
                .i_valid       (valid_vec[g]),
                .i_left_lt     (left_lt),
                .i_left_entry  (left_entry),
                .i_right_entry (right_entry),
                .i_rm_sel      (rm_sel[g]),
                .i_rd_sel      (rd_sel[g]),
                .o_lt          (lt_vec[g]),
                .o_eq          (eq_vec[g]),
                .o_entry       (cell_entry[g]),
                .o_rd_value    (cell_rd[g])
            );
        end
    endgenerate

    // lt_vec is a thermometer code; its edge gives the count of smaller entries
    assign lt_ext = {1'b0, lt_vec};

    always_comb begin
        smaller = '0;
        rd_any  = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (lt_ext[i] && !lt_ext[i+1]) begin
                smaller = smaller | CW'(i + 1);
            end
            rd_any = rd_any | cell_rd[i];
        end
    end

    always_comb begin
        ok_c    = 1'b0;
        rd_c    = '0;
        rank_c  = '0;
        n_count = r_count;
        unique case (in_op)
            OP_INSERT: begin
                ok_c = !full;
                if (!full) begin
                    n_count = r_count + CW'(1);
                end
            end
            OP_REMOVE_VALUE: begin
                ok_c = found;
                if (found) begin
                    n_count = r_count - CW'(1);
                end
            end
            OP_REMOVE_AT: begin
                ok_c = pos_ok;
                if (pos_ok) begin
                    n_count = r_count - CW'(1);
                end
            end
            OP_FIND_RANK: begin
                ok_c = !empty;
                if (!empty) begin
                    rank_c = (PW + 1)'(smaller) + (PW + 1)'(1);
                end
            end
            OP_READ_AT: begin
                ok_c = !empty;
                if (!empty) begin
                    rd_c = rd_any;
                end
            end
            OP_CLEAR: begin
                ok_c    = !empty;
                n_count = '0;
            end
            default: begin
            end
        endcase
    end

    assign cnt_next_ext = PW'(n_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count <= n_count;
            end
            if (accept) begin
                r_m_valid <= 1'b1;
            end else if (m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ok      <= ok_c;
            r_rd      <= rd_c;
            r_rank    <= rank_c[RANK_W-1:0];
            r_cnt_out <= cnt_next_ext[CNT_W-1:0];
        end
    end

    assign m_tvalid = r_m_valid;
    assign m_tdata  = {5'b0, r_cnt_out, r_rank, r_rd, r_ok};

endmodule

@@ hdl/ste_cell.sv @@
// ----------------------------------------------------------------------------
// ste_cell
// One slot of the sorted chain: holds one entry, compares it against the
// broadcast value and takes the new value or its left or right neighbor's entry on a shift.
// ----------------------------------------------------------------------------
module ste_cell (
    input  logic                              i_clk,
    input  ste_pkg::t_cell_cmd                i_cmd,
    input  logic                              i_valid,      // slot holds an entry
    input  logic                              i_left_lt,    // left neighbor < value
    input  logic signed [ste_pkg::VAL_W-1:0]  i_left_entry,
    input  logic signed [ste_pkg::VAL_W-1:0]  i_right_entry,
    input  logic                              i_rm_sel,     // at or after remove position
    input  logic                              i_rd_sel,     // read slot
    output logic                              o_lt,
    output logic                              o_eq,
    output logic signed [ste_pkg::VAL_W-1:0]  o_entry,
    output logic signed [ste_pkg::VAL_W-1:0]  o_rd_value
);
    import ste_pkg::*;

    logic signed [VAL_W-1:0] r_entry;
    logic signed [VAL_W-1:0] n_entry;

    assign o_lt       = i_valid && (r_entry < i_cmd.value);
    assign o_eq       = i_valid && (r_entry == i_cmd.value);
    assign o_entry    = r_entry;
    assign o_rd_value = i_rd_sel ? r_entry : '0;

    always_comb begin
        n_entry = r_entry;
        if (i_cmd.ins_en && !o_lt) begin
            // first non-smaller slot takes the new value, the rest shift up
            n_entry = i_left_lt ? i_cmd.value : i_left_entry;
        end else if ((i_cmd.rmv_en && !o_lt) || (i_cmd.rma_en && i_rm_sel)) begin
            n_entry = i_right_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule
